/* hw/rtl/fpst_pkg.sv */
// Package for the Fenwick prefix-sum table unit: store geometry, operation codes,
// microcode word layout and the control program ROM.
// No dependencies; imported by fenwick_prefix_sum_table_unit.
package fpst_pkg;

    // Store geometry
    localparam int DEPTH  = 1024;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = IDX_W + 1;
    // Remaining descend target grows by at most 2^31 per tree level
    localparam int TGT_W  = 32 + $clog2(CNT_W + 1) + 1;

    // Fixed field widths
    localparam int SIZE_W = 11;
    localparam int POS_W  = 10;
    localparam int DATA_W = 32;
    localparam int SUM_W  = 33;

    // Operation codes carried in the mode field
    localparam logic [1:0] MODE_ADD   = 2'd0;
    localparam logic [1:0] MODE_RANGE = 2'd1;
    localparam logic [1:0] MODE_DESC  = 2'd2;
    localparam logic [1:0] MODE_NONE  = 2'd3;

    // Datapath actions, one per control word
    typedef enum logic [4:0] {
        ACT_NOP,
        ACT_CLEAR,
        ACT_LOAD,
        ACT_ADD_INIT,
        ACT_RD_I,
        ACT_ADD_WR,
        ACT_RNG_INIT,
        ACT_RD_K,
        ACT_ACC,
        ACT_RNG_MID,
        ACT_DIFF,
        ACT_DSC_INIT,
        ACT_RD_U,
        ACT_DSC_CMP,
        ACT_SHIFT,
        ACT_FOUND,
        ACT_OUT
    } act_t;

    // Jump conditions
    typedef enum logic [3:0] {
        COND_NONE,
        COND_ALWAYS,
        COND_DISPATCH,
        COND_CLR_MORE,
        COND_IDX_GE_N,
        COND_EMPTY,
        COND_IDX_ZERO,
        COND_U_GE_N,
        COND_BIT_MORE,
        COND_OUT_FREE
    } cond_t;

    localparam int STEP_W = 5;
    typedef logic [STEP_W-1:0] step_t;

    // Program steps
    localparam step_t S_CLR      = 5'd0;
    localparam step_t S_IDLE     = 5'd1;
    localparam step_t S_ADD_INIT = 5'd2;
    localparam step_t S_ADD_RD   = 5'd3;
    localparam step_t S_ADD_WR   = 5'd4;
    localparam step_t S_RNG_INIT = 5'd5;
    localparam step_t S_PR_RD    = 5'd6;
    localparam step_t S_PR_ACC   = 5'd7;
    localparam step_t S_RNG_MID  = 5'd8;
    localparam step_t S_PL_RD    = 5'd9;
    localparam step_t S_PL_ACC   = 5'd10;
    localparam step_t S_RNG_END  = 5'd11;
    localparam step_t S_DSC_INIT = 5'd12;
    localparam step_t S_DSC_RD   = 5'd13;
    localparam step_t S_DSC_CMP  = 5'd14;
    localparam step_t S_DSC_NEXT = 5'd15;
    localparam step_t S_DSC_END  = 5'd16;
    localparam step_t S_FIN      = 5'd17;

    // Control word: on a hit jump to target (on dispatch, to the entry step of the mode), else hold or step on
    typedef struct packed {
        act_t  act;
        cond_t cond;
        logic  hold;
        step_t target;
    } ucode_t;

    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t w;
        unique case (step)
            S_CLR:      w = '{ACT_CLEAR,    COND_CLR_MORE, 1'b0, S_CLR};
            S_IDLE:     w = '{ACT_LOAD,     COND_DISPATCH, 1'b1, S_IDLE};
            S_ADD_INIT: w = '{ACT_ADD_INIT, COND_NONE,     1'b0, S_IDLE};
            S_ADD_RD:   w = '{ACT_RD_I,     COND_IDX_GE_N, 1'b0, S_FIN};
            S_ADD_WR:   w = '{ACT_ADD_WR,   COND_ALWAYS,   1'b0, S_ADD_RD};
            S_RNG_INIT: w = '{ACT_RNG_INIT, COND_EMPTY,    1'b0, S_FIN};
            S_PR_RD:    w = '{ACT_RD_K,     COND_IDX_ZERO, 1'b0, S_RNG_MID};
            S_PR_ACC:   w = '{ACT_ACC,      COND_ALWAYS,   1'b0, S_PR_RD};
            S_RNG_MID:  w = '{ACT_RNG_MID,  COND_NONE,     1'b0, S_IDLE};
            S_PL_RD:    w = '{ACT_RD_K,     COND_IDX_ZERO, 1'b0, S_RNG_END};
            S_PL_ACC:   w = '{ACT_ACC,      COND_ALWAYS,   1'b0, S_PL_RD};
            S_RNG_END:  w = '{ACT_DIFF,     COND_ALWAYS,   1'b0, S_FIN};
            S_DSC_INIT: w = '{ACT_DSC_INIT, COND_NONE,     1'b0, S_IDLE};
            S_DSC_RD:   w = '{ACT_RD_U,     COND_U_GE_N,   1'b0, S_DSC_NEXT};
            S_DSC_CMP:  w = '{ACT_DSC_CMP,  COND_NONE,     1'b0, S_IDLE};
            S_DSC_NEXT: w = '{ACT_SHIFT,    COND_BIT_MORE, 1'b0, S_DSC_RD};
            S_DSC_END:  w = '{ACT_FOUND,    COND_NONE,     1'b0, S_IDLE};
            S_FIN:      w = '{ACT_OUT,      COND_OUT_FREE, 1'b1, S_IDLE};
            default:    w = '{ACT_NOP,      COND_ALWAYS,   1'b0, S_IDLE};
        endcase
        return w;
    endfunction

    // Entry step for each operation code
    function automatic step_t mode_entry(input logic [1:0] mode);
        step_t s;
        unique case (mode)
            MODE_ADD:   s = S_ADD_INIT;
            MODE_RANGE: s = S_RNG_INIT;
            MODE_DESC:  s = S_DSC_INIT;
            MODE_NONE:  s = S_FIN;
        endcase
        return s;
    endfunction

endpackage

/* hw/rtl/fenwick_prefix_sum_table_unit.sv */
// Fenwick prefix-sum table unit: binary indexed tree over a 1024-entry store of
// signed 32-bit partial sums, run by a microcoded sequencer.
// Depends on fpst_pkg (geometry, action/condition codes, control program ROM).

// One request is handled at a time. Each store read on a tree chain is a
// registered read followed by an accumulate or a write back; a descend level
// reads a node, compares it with the remaining target and shifts the level mask,
// skipping the compare when the node lies beyond the size in use. After reset
// the unit clears all 1024 store entries and takes no request until that pass
// is done; configuration writes are taken at any time. A finished result sits
// in an output register, so the next request is taken while it waits.
module fenwick_prefix_sum_table_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              cfg_we,
    input  logic [fpst_pkg::SIZE_W-1:0]       cfg_wdata,
    // request channel
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        mode,
    input  logic [fpst_pkg::POS_W-1:0]        position,
    input  logic [fpst_pkg::POS_W-1:0]        right_end,
    input  logic signed [fpst_pkg::DATA_W-1:0] amount,
    // result channel
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [fpst_pkg::SUM_W-1:0] range_sum,
    output logic [fpst_pkg::SIZE_W-1:0]       found_position,
    output logic                              overflow
);
    import fpst_pkg::*;

    // Sequencer state
    step_t  pc_reg, pc_next;
    ucode_t uc;
    logic   cond_hit;

    // Configuration
    logic [SIZE_W-1:0] size_reg;
    logic [CNT_W-1:0]  n_act;

    // Datapath registers
    logic [CNT_W-1:0]         idx_reg, idx_next;
    logic [CNT_W-1:0]         bit_reg, bit_next;
    logic [POS_W-1:0]         pos_reg, pos_next;
    logic [POS_W-1:0]         right_reg, right_next;
    logic [DATA_W-1:0]        amt_reg, amt_next;
    logic [DATA_W-1:0]        acc_reg, acc_next;
    logic [DATA_W-1:0]        hold_reg, hold_next;
    logic signed [TGT_W-1:0]  tgt_reg, tgt_next;
    logic signed [SUM_W-1:0]  sum_res_reg, sum_res_next;
    logic [SIZE_W-1:0]        found_res_reg, found_res_next;
    logic                     ovf_res_reg, ovf_res_next;

    // Output register
    logic                     out_valid_reg, out_valid_next;
    logic signed [SUM_W-1:0]  out_sum_reg, out_sum_next;
    logic [SIZE_W-1:0]        out_found_reg, out_found_next;
    logic                     out_ovf_reg, out_ovf_next;

    // Store
    logic [DATA_W-1:0] partial_sums_reg [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;
    logic              mem_rd_en, mem_wr_en;
    logic [IDX_W-1:0]  mem_rd_addr, mem_wr_addr;
    logic [DATA_W-1:0] mem_wr_data;

    // Derived datapath values
    logic [CNT_W-1:0]         k_minus1, u_idx, right_p1, right_k, left_k;
    logic [DATA_W-1:0]        add_sum;
    logic                     add_ovf;
    logic signed [TGT_W-1:0]  rd_ext;
    logic                     out_free;

    // Effective size: zero acts as one, above depth acts as depth
    always_comb
    begin
        if (size_reg == '0)
            n_act = CNT_W'(1);
        else if (32'(size_reg) > DEPTH)
            n_act = CNT_W'(DEPTH);
        else
            n_act = CNT_W'(size_reg);
    end

    // Shared arithmetic
    assign k_minus1 = idx_reg - CNT_W'(1);
    assign u_idx    = idx_reg + bit_reg - CNT_W'(1);
    assign right_p1 = CNT_W'(right_reg) + CNT_W'(1);
    assign right_k  = (right_p1 > n_act) ? n_act : right_p1;
    assign left_k   = (CNT_W'(pos_reg) > n_act) ? n_act : CNT_W'(pos_reg);
    assign add_sum  = rd_data_reg + amt_reg;
    assign add_ovf  = (rd_data_reg[DATA_W-1] == amt_reg[DATA_W-1]) &&
                      (add_sum[DATA_W-1] != rd_data_reg[DATA_W-1]);
    assign rd_ext   = {{(TGT_W-DATA_W){rd_data_reg[DATA_W-1]}}, rd_data_reg};
    assign out_free = !out_valid_reg || out_ready;

    // Control word fetch
    assign uc = ucode_rom(pc_reg);

    // Jump condition
    always_comb
    begin
        unique case (uc.cond)
            COND_NONE:     cond_hit = 1'b0;
            COND_ALWAYS:   cond_hit = 1'b1;
            COND_DISPATCH: cond_hit = in_valid;
            COND_CLR_MORE: cond_hit = (idx_reg != CNT_W'(DEPTH - 1));
            COND_IDX_GE_N: cond_hit = (idx_reg >= n_act);
            COND_EMPTY:    cond_hit = (pos_reg > right_reg);
            COND_IDX_ZERO: cond_hit = (idx_reg == '0);
            COND_U_GE_N:   cond_hit = (u_idx >= n_act);
            COND_BIT_MORE: cond_hit = !bit_reg[0];
            COND_OUT_FREE: cond_hit = out_free;
            default:       cond_hit = 1'b0;
        endcase
    end

    // Next step
    always_comb
    begin
        if (cond_hit)
            pc_next = (uc.cond == COND_DISPATCH) ? mode_entry(mode) : uc.target;
        else if (uc.hold)
            pc_next = pc_reg;
        else
            pc_next = pc_reg + step_t'(1);
    end

    // Datapath actions
    always_comb
    begin
        idx_next       = idx_reg;
        bit_next       = bit_reg;
        pos_next       = pos_reg;
        right_next     = right_reg;
        amt_next       = amt_reg;
        acc_next       = acc_reg;
        hold_next      = hold_reg;
        tgt_next       = tgt_reg;
        sum_res_next   = sum_res_reg;
        found_res_next = found_res_reg;
        ovf_res_next   = ovf_res_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_sum_next   = out_sum_reg;
        out_found_next = out_found_reg;
        out_ovf_next   = out_ovf_reg;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = idx_reg[IDX_W-1:0];
        mem_wr_en      = 1'b0;
        mem_wr_addr    = idx_reg[IDX_W-1:0];
        mem_wr_data    = '0;

        unique case (uc.act)
            ACT_NOP:
            begin
            end
            ACT_CLEAR:
            begin
                mem_wr_en = 1'b1;
                idx_next  = idx_reg + CNT_W'(1);
            end
            ACT_LOAD:
            begin
                if (in_valid)
                begin
                    pos_next   = position;
                    right_next = right_end;
                    amt_next   = amount;
                end
                sum_res_next   = '0;
                found_res_next = '0;
                ovf_res_next   = 1'b0;
            end
            ACT_ADD_INIT:
                idx_next = CNT_W'(pos_reg);
            ACT_RD_I:
                mem_rd_en = 1'b1;
            ACT_ADD_WR:
            begin
                mem_wr_en    = 1'b1;
                mem_wr_data  = add_sum;
                ovf_res_next = ovf_res_reg | add_ovf;
                idx_next     = idx_reg | (idx_reg + CNT_W'(1));
            end
            ACT_RNG_INIT:
            begin
                idx_next = right_k;
                acc_next = '0;
            end
            ACT_RD_K:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = k_minus1[IDX_W-1:0];
            end
            ACT_ACC:
            begin
                acc_next = acc_reg + rd_data_reg;
                idx_next = idx_reg & k_minus1;
            end
            ACT_RNG_MID:
            begin
                hold_next = acc_reg;
                acc_next  = '0;
                idx_next  = left_k;
            end
            ACT_DIFF:
                sum_res_next = $signed({hold_reg[DATA_W-1], hold_reg}) -
                               $signed({acc_reg[DATA_W-1], acc_reg});
            ACT_DSC_INIT:
            begin
                idx_next = '0;
                bit_next = {1'b1, {(CNT_W-1){1'b0}}};
                tgt_next = {{(TGT_W-DATA_W){amt_reg[DATA_W-1]}}, amt_reg};
            end
            ACT_RD_U:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = u_idx[IDX_W-1:0];
            end
            ACT_DSC_CMP:
            begin
                if (rd_ext < tgt_reg)
                begin
                    tgt_next = tgt_reg - rd_ext;
                    idx_next = idx_reg + bit_reg;
                end
            end
            ACT_SHIFT:
                bit_next = bit_reg >> 1;
            ACT_FOUND:
                found_res_next = SIZE_W'(idx_reg);
            ACT_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_sum_next   = sum_res_reg;
                    out_found_next = found_res_reg;
                    out_ovf_next   = ovf_res_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= S_CLR;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            size_reg      <= SIZE_W'(DEPTH);
        end
        else
        begin
            pc_reg        <= pc_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                size_reg <= cfg_wdata;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        bit_reg       <= bit_next;
        pos_reg       <= pos_next;
        right_reg     <= right_next;
        amt_reg       <= amt_next;
        acc_reg       <= acc_next;
        hold_reg      <= hold_next;
        tgt_reg       <= tgt_next;
        sum_res_reg   <= sum_res_next;
        found_res_reg <= found_res_next;
        ovf_res_reg   <= ovf_res_next;
        out_sum_reg   <= out_sum_next;
        out_found_reg <= out_found_next;
        out_ovf_reg   <= out_ovf_next;
    end

    // Store write port
    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
            partial_sums_reg[mem_wr_addr] <= mem_wr_data;
    end

    // Store read port, registered
    always_ff @(posedge clk)
    begin
        if (mem_rd_en)
            rd_data_reg <= partial_sums_reg[mem_rd_addr];
    end

    // Ports
    assign in_ready       = (pc_reg == S_IDLE);
    assign out_valid      = out_valid_reg;
    assign range_sum      = out_sum_reg;
    assign found_position = out_found_reg;
    assign overflow       = out_ovf_reg;

    // Checks
    a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (uc.act == ACT_ADD_WR) |-> (idx_reg < n_act))
        else $error("update writes beyond the size in use");

    a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(pc_reg) == S_FIN))
        else $error("result raised outside the finish step");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (pc_reg != S_IDLE))
        else $error("accepted request did not start the program");

    a_desc_bit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == S_DSC_RD) |-> $onehot(bit_reg))
        else $error("descend level mask is not one-hot");

endmodule

/* dv/tb.sv */
// Testbench for fenwick_prefix_sum_table_unit: a directed table followed by random
// phases at several tree sizes, with every result checked against a typed-in value or an internal predictor.
// Depends on fpst_pkg and the fenwick_prefix_sum_table_unit RTL.
`timescale 1ns / 100ps

module tb;

    import fpst_pkg::*;

    localparam int NUM_PHASES = 12;
    localparam int PHASE_ITEMS = 125;

    typedef struct packed {
        logic [1:0]         mode;
        logic [POS_W-1:0]   pos;
        logic [POS_W-1:0]   right;
        logic signed [31:0] amt;
    } req_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic [SIZE_W-1:0]       found;
        logic                    ovf;
    } result_t;

    // One directed row: optional size write first, then a request
    typedef struct packed {
        logic              cfg_en;
        logic [SIZE_W-1:0] cfg_val;
        logic              fixed;
        result_t           typed;
        req_t              rq;
    } row_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_we = 1'b0;
    logic [SIZE_W-1:0]        cfg_wdata = '0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [1:0]               mode = MODE_ADD;
    logic [POS_W-1:0]         position = '0;
    logic [POS_W-1:0]         right_end = '0;
    logic signed [DATA_W-1:0] amount = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic signed [SUM_W-1:0]  range_sum;
    logic [SIZE_W-1:0]        found_position;
    logic                     overflow;

    // Predictor state: tree store and size register
    logic [31:0]       part_sum [0:DEPTH-1];
    logic [SIZE_W-1:0] size_reg;

    result_t want_q [$];
    row_t    dir_tab [$];
    int      err_cnt = 0;
    bit      idle_on = 1'b0;

    fenwick_prefix_sum_table_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .position       (position),
        .right_end      (right_end),
        .amount         (amount),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .range_sum      (range_sum),
        .found_position (found_position),
        .overflow       (overflow)
    );

    always #4 clk = ~clk;

    // Size actually used: 0 counts as 1, anything above the store depth as the depth
    function automatic int live_size();
        if (size_reg == 0)
            return 1;
        if (size_reg > DEPTH)
            return DEPTH;
        return int'(size_reg);
    endfunction

    // Prefix sum over positions 0..j, wrapped to 32 bits
    function automatic logic signed [31:0] tree_prefix(input int j, input int n);
        logic [31:0] acc;
        int          i;
        acc = '0;
        if (j > n - 1)
            j = n - 1;
        for (i = j; i >= 0; i = (i & (i + 1)) - 1)
            acc = acc + part_sum[i];
        return acc;
    endfunction

    // Expected result of one request; updates the store for adds
    function automatic result_t predict_request(input req_t r);
        result_t res;
        int      n, i, k, levels, v, u;
        longint  nv, d, tgt, e;
        res = '0;
        n = live_size();
        case (r.mode)
            MODE_ADD:
            begin
                for (i = int'(r.pos); i < n; i = i | (i + 1))
                begin
                    nv = longint'($signed(part_sum[i])) + longint'($signed(r.amt));
                    if (nv > 64'sd2147483647 || nv < -64'sd2147483648)
                        res.ovf = 1'b1;
                    part_sum[i] = nv[31:0];
                end
            end
            MODE_RANGE:
            begin
                if (r.pos <= r.right)
                begin
                    d = longint'(tree_prefix(int'(r.right), n))
                        - longint'(tree_prefix(int'(r.pos) - 1, n));
                    res.sum = d[SUM_W-1:0];
                end
            end
            MODE_DESC:
            begin
                levels = 0;
                while (levels < 40 && (n >> levels) != 0)
                    levels++;
                v = 0;
                tgt = longint'($signed(r.amt));
                for (k = levels - 1; k >= 0; k--)
                begin
                    u = v + (1 << k) - 1;
                    if (u < n)
                    begin
                        e = longint'($signed(part_sum[u]));
                        if (e < tgt)
                        begin
                            tgt = tgt - e;
                            v = u + 1;
                        end
                    end
                end
                res.found = v[SIZE_W-1:0];
            end
            default: ;
        endcase
        return res;
    endfunction

    // Offer one request, wait for acceptance, then record what should come back
    task automatic issue(input req_t r, input bit fixed, input result_t typed);
        result_t pred;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        in_valid  <= 1'b1;
        mode      <= r.mode;
        position  <= r.pos;
        right_end <= r.right;
        amount    <= r.amt;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pred = predict_request(r);
        want_q.push_back(fixed ? typed : pred);
    endtask

    // Stop sending and wait until every outstanding request has returned
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (want_q.size() != 0)
            @(posedge clk);
    endtask

    // Size write, only while the unit is idle
    task automatic write_size(input logic [SIZE_W-1:0] val);
        drain();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        size_reg = val;
    endtask

    function automatic row_t mk_row(input bit cfg_en, input int cfg_val, input logic [1:0] m,
                                    input int p, input int rr, input logic [31:0] a,
                                    input bit fx, input longint s, input int f, input bit o);
        row_t row;
        row.cfg_en      = cfg_en;
        row.cfg_val     = cfg_val[SIZE_W-1:0];
        row.fixed       = fx;
        row.typed.sum   = s[SUM_W-1:0];
        row.typed.found = f[SIZE_W-1:0];
        row.typed.ovf   = o;
        row.rq.mode     = m;
        row.rq.pos      = p[POS_W-1:0];
        row.rq.right    = rr[POS_W-1:0];
        row.rq.amt      = a;
        return row;
    endfunction

    // Directed rows; known results typed in, the rest left to the predictor
    task automatic build_table();
        // empty tree at full size
        dir_tab.push_back(mk_row(0, 0, MODE_RANGE, 0, 1023, 32'h0, 1, 0, 0, 0));
        dir_tab.push_back(mk_row(0, 0, MODE_DESC, 0, 0, 32'h0, 1, 0, 0, 0));
        dir_tab.push_back(mk_row(0, 0, MODE_DESC, 0, 0, 32'h1, 1, 0, 1024, 0));
        dir_tab.push_back(mk_row(0, 0, MODE_DESC, 0, 0, 32'h8000_0000, 1, 0, 0, 0));
        // wrap on the update chain from position 0
        dir_tab.push_back(mk_row(0, 0, MODE_ADD, 0, 0, 32'h7FFF_FFFF, 1, 0, 0, 0));
        dir_tab.push_back(mk_row(0, 0, MODE_ADD, 0, 0, 32'h1, 1, 0, 0, 1));
        dir_tab.push_back(mk_row(0, 0, MODE_ADD, 1023, 0, 32'h8000_0000, 0, 0, 0, 0));
        dir_tab.push_back(mk_row(0, 0, MODE_ADD, 512, 0, 32'hFFFF_FFFF, 0, 0, 0, 0));
        // empty range and unused mode
        dir_tab.push_back(mk_row(0, 0, MODE_RANGE, 5, 4, 32'h0, 1, 0, 0, 0));
        dir_tab.push_back(mk_row(0, 0, MODE_NONE, 1023, 1023, 32'hFFFF_FFFF, 1, 0, 0, 0));
        dir_tab.push_back(mk_row(0, 0, MODE_RANGE, 0, 0, 32'h0, 0, 0, 0, 0));
        dir_tab.push_back(mk_row(0, 0, MODE_RANGE, 1023, 1023, 32'h0, 0, 0, 0, 0));
        dir_tab.push_back(mk_row(0, 0, MODE_RANGE, 0, 1023, 32'h0, 0, 0, 0, 0));
        dir_tab.push_back(mk_row(0, 0, MODE_DESC, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 0));
        dir_tab.push_back(mk_row(0, 0, MODE_DESC, 0, 0, 32'h1, 0, 0, 0, 0));
        // shrink to 8: add beyond size, range beyond size, clamped right end
        dir_tab.push_back(mk_row(1, 8, MODE_ADD, 8, 0, 32'h5, 1, 0, 0, 0));
        dir_tab.push_back(mk_row(0, 0, MODE_RANGE, 8, 1023, 32'h0, 1, 0, 0, 0));
        dir_tab.push_back(mk_row(0, 0, MODE_RANGE, 3, 1023, 32'h0, 0, 0, 0, 0));
        dir_tab.push_back(mk_row(0, 0, MODE_DESC, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 0));
        dir_tab.push_back(mk_row(0, 0, MODE_ADD, 7, 0, 32'd123, 0, 0, 0, 0));
        // size 0 behaves as 1
        dir_tab.push_back(mk_row(1, 0, MODE_ADD, 0, 0, 32'hFFFF_FFFB, 0, 0, 0, 0));
        dir_tab.push_back(mk_row(0, 0, MODE_DESC, 0, 0, 32'd3, 0, 0, 0, 0));
        // size above depth behaves as depth
        dir_tab.push_back(mk_row(1, 2047, MODE_RANGE, 0, 1023, 32'h0, 0, 0, 0, 0));
        dir_tab.push_back(mk_row(0, 0, MODE_DESC, 0, 0, 32'd100, 0, 0, 0, 0));
    endtask

    // Random request shaped to hit live positions, extremes and real prefix targets
    function automatic req_t rand_request();
        req_t r;
        int   n, sel;
        n = live_size();
        sel = $urandom_range(0, 99);
        if (sel < 35)
            r.mode = MODE_ADD;
        else if (sel < 65)
            r.mode = MODE_RANGE;
        else if (sel < 95)
            r.mode = MODE_DESC;
        else
            r.mode = MODE_NONE;
        r.pos   = ($urandom_range(0, 99) < 85) ? POS_W'($urandom_range(0, n - 1))
                                                : POS_W'($urandom_range(0, 1023));
        r.right = ($urandom_range(0, 99) < 70) ? POS_W'($urandom_range(0, n - 1))
                                                : POS_W'($urandom_range(0, 1023));
        sel = $urandom_range(0, 99);
        if (sel < 35)
            r.amt = 32'($urandom_range(0, 2000)) - 32'sd1000;
        else if (sel < 60)
            r.amt = $urandom;
        else if (sel < 75)
        begin
            case ($urandom_range(0, 4))
                0: r.amt = 32'h7FFF_FFFF;
                1: r.amt = 32'h8000_0000;
                2: r.amt = 32'h0;
                3: r.amt = 32'h1;
                default: r.amt = 32'hFFFF_FFFF;
            endcase
        end
        else
            r.amt = tree_prefix($urandom_range(0, n - 1), n) + 32'($urandom_range(0, 2)) - 32'sd1;
        return r;
    endfunction

    // Result side: random stall bursts
    int stall_left = 0;
    always @(negedge clk)
    begin
        if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 7);
        if (stall_left != 0)
        begin
            out_ready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else
            out_ready <= 1'b1;
    end

    // Compare each returned result with the oldest expectation
    always @(posedge clk)
    begin
        result_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            if (want_q.size() == 0)
            begin
                err_cnt++;
                $display("%0t: unexpected result sum=%0d found=%0d ovf=%0b",
                         $realtime, range_sum, found_position, overflow);
            end
            else
            begin
                exp_r = want_q.pop_front();
                if (range_sum !== exp_r.sum)
                begin
                    err_cnt++;
                    $display("%0t: range_sum expected %0d got %0d",
                             $realtime, exp_r.sum, range_sum);
                end
                if (found_position !== exp_r.found)
                begin
                    err_cnt++;
                    $display("%0t: found_position expected %0d got %0d",
                             $realtime, exp_r.found, found_position);
                end
                if (overflow !== exp_r.ovf)
                begin
                    err_cnt++;
                    $display("%0t: overflow expected %0b got %0b",
                             $realtime, exp_r.ovf, overflow);
                end
            end
        end
    end

    // Hard stop well past the slowest correct run
    initial
    begin
        #4_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Main sequence
    initial
    begin
        int      ph, it;
        int      sizes [NUM_PHASES];
        result_t none;
        none = '0;
        sizes = '{1024, 1, 2, 3, 16, 100, 0, 2047, 1000, 513, 7, 0};
        sizes[NUM_PHASES-1] = $urandom_range(1, 1024);
        for (it = 0; it < DEPTH; it++)
            part_sum[it] = '0;
        size_reg = 11'd1024;

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // directed part
        idle_on = 1'b1;
        build_table();
        foreach (dir_tab[i])
        begin
            if (dir_tab[i].cfg_en)
                write_size(dir_tab[i].cfg_val);
            issue(dir_tab[i].rq, dir_tab[i].fixed, dir_tab[i].typed);
        end

        // random phases, each at its own size; the last ones run without idling
        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            write_size(SIZE_W'(sizes[ph]));
            idle_on = (ph < NUM_PHASES - 2) && ($urandom_range(0, 3) != 0);
            for (it = 0; it < PHASE_ITEMS; it++)
            begin
                if (ph == 3 && it == PHASE_ITEMS / 2)
                    drain();
                issue(rand_request(), 1'b0, none);
            end
        end

        drain();
        repeat (64) @(posedge clk);
        if (err_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
